// File: rtl/core/tbsb_pkg.sv
// Shared types, codes and default sizes for the threshold weighted separable blur.
package tbsb_pkg;

  localparam int DefMaxWidth  = 256;
  localparam int DefMaxHeight = 256;
  localparam int DefMaxRadius = 31;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 9;

  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RADIUS       = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD    = 2'd3;

  localparam logic [8:0] RstFrameWidth  = 9'd256;
  localparam logic [8:0] RstFrameHeight = 9'd256;
  localparam logic [4:0] RstRadius      = 5'd30;
  localparam logic [8:0] RstThreshold   = 9'd1;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TAP   = 5'b00010,
    S_LAST  = 5'b00100,
    S_DIV   = 5'b01000,
    S_WRITE = 5'b10000
  } eng_state_t;

endpackage

// File: rtl/core/threshold_weighted_separable_blur.sv
// Top level of the threshold weighted separable blur: command decode, frame stores, filter engine.
//
//  channel   | handshake          | signals
//  ----------+--------------------+-------------------------------------------
//  command   | start, busy        | func, col, row, pixel_value
//  result    | done (strobe)      | read_pixel, run_done, status
//  config    | cfg_we             | cfg_index, cfg_data
//
// A command transfers at a clock edge where start is high and busy is low.
// Pixel writes, reads and the unused code may follow back to back; their
// result is strobed on done in the cycle after the transfer.
// A run holds busy high until its last write: each output pixel of both passes
// reads one tap per cycle through a single store read port, adds in the last
// tap in a separate step, then goes through the shared restoring divider and
// the write.
// Its result (run_done) is strobed in the cycle where busy falls.
// Reset is synchronous; it clears the control state and restores the register
// defaults but not the frame stores. The receiver cannot stall the result.
module threshold_weighted_separable_blur
  import tbsb_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight,
  parameter int MAX_RADIUS = DefMaxRadius
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          func,
  input  logic [7:0]          col,
  input  logic [7:0]          row,
  input  logic [7:0]          pixel_value,
  output logic                done,
  output logic [7:0]          read_pixel,
  output logic                run_done,
  output logic                status,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RHW  = $clog2(MAX_HEIGHT);
  localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int RADW = $clog2(MAX_RADIUS + 1);
  localparam int DW   = $clog2(MAX_WIDTH + 1);
  localparam int DHW  = $clog2(MAX_HEIGHT + 1);

  // Configuration registers.
  logic [8:0] frame_width;
  logic [8:0] frame_height;
  logic [4:0] radius;
  logic [8:0] threshold;

  // Effective frame size and radius after range limiting.
  logic [DW-1:0]   w_lim;
  logic [DHW-1:0]  h_lim;
  logic [RADW-1:0] r_lim;
  logic [CW-1:0]   last_x;
  logic [RHW-1:0]  last_y;

  logic          accept;
  func_t         cmd;
  logic          in_frame;
  logic [AW-1:0] cmd_addr;

  logic          rsp_v;
  logic          rsp_read;
  logic          rsp_status;

  logic          eng_busy;
  logic          eng_done;
  logic [AW-1:0] src_raddr;
  logic [7:0]    src_rdata;
  logic          res_we;
  logic [AW-1:0] res_waddr;
  logic [7:0]    res_wdata;
  logic [7:0]    res_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RstFrameWidth;
      frame_height <= RstFrameHeight;
      radius       <= RstRadius;
      threshold    <= RstThreshold;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        CFG_RADIUS:       radius       <= cfg_data[4:0];
        CFG_THRESHOLD:    threshold    <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero size acts as one, and a size above the store acts as the store size.
  always_comb begin
    if (frame_width == 9'd0) begin
      w_lim = DW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_lim = DW'(MAX_WIDTH);
    end else begin
      w_lim = DW'(frame_width);
    end
    if (frame_height == 9'd0) begin
      h_lim = DHW'(1);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_lim = DHW'(MAX_HEIGHT);
    end else begin
      h_lim = DHW'(frame_height);
    end
    if (32'(radius) > 32'(MAX_RADIUS)) begin
      r_lim = RADW'(MAX_RADIUS);
    end else begin
      r_lim = RADW'(radius);
    end
  end

  assign last_x = CW'(w_lim - DW'(1));
  assign last_y = RHW'(h_lim - DHW'(1));

  assign busy     = eng_busy;
  assign accept   = start && !busy;
  assign cmd      = func_t'(func);
  assign in_frame = (32'(col) < 32'(w_lim)) && (32'(row) < 32'(h_lim));
  assign cmd_addr = AW'(AW'(row) * AW'(MAX_WIDTH) + AW'(col));

  // Source store: written by pixel writes, read by the horizontal pass.
  tbsb_ram #(
    .WIDTH(8),
    .DEPTH(MAX_WIDTH * MAX_HEIGHT)
  ) u_source (
    .clk  (clk),
    .we   (accept && (cmd == FUNC_WRITE) && in_frame),
    .waddr(cmd_addr),
    .wdata(pixel_value),
    .raddr(src_raddr),
    .rdata(src_rdata)
  );

  // Result store: written by the vertical pass, read by pixel reads.
  tbsb_ram #(
    .WIDTH(8),
    .DEPTH(MAX_WIDTH * MAX_HEIGHT)
  ) u_result (
    .clk  (clk),
    .we   (res_we),
    .waddr(res_waddr),
    .wdata(res_wdata),
    .raddr(cmd_addr),
    .rdata(res_rdata)
  );

  tbsb_engine #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .go       (accept && (cmd == FUNC_RUN)),
    .last_x   (last_x),
    .last_y   (last_y),
    .r        (r_lim),
    .thr      (threshold),
    .busy     (eng_busy),
    .done     (eng_done),
    .src_raddr(src_raddr),
    .src_rdata(src_rdata),
    .res_we   (res_we),
    .res_waddr(res_waddr),
    .res_wdata(res_wdata)
  );

  // Commands other than a run answer in the next cycle; the read data comes
  // straight from the result store's output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_v <= 1'b0;
    end else begin
      rsp_v <= accept && (cmd != FUNC_RUN);
    end
    rsp_read   <= (cmd == FUNC_READ) && in_frame;
    rsp_status <= ((cmd == FUNC_WRITE) || (cmd == FUNC_READ)) && !in_frame;
  end

  assign done       = rsp_v || eng_done;
  assign run_done   = eng_done;
  assign read_pixel = (rsp_v && rsp_read) ? res_rdata : 8'd0;
  assign status     = rsp_v && rsp_status;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rsp_v && eng_done))
    else $error("command result and run completion in the same cycle");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == FUNC_RUN)) |=> busy)
    else $error("run transfer did not raise busy");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    run_done |-> !status && (read_pixel == 8'd0))
    else $error("run completion carries read data or status");

endmodule

// File: rtl/core/tbsb_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tbsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/tbsb_engine.sv
// Two-pass filter sequencer: one tap per cycle into a shared accumulator, then a shared divider.
module tbsb_engine
  import tbsb_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight,
  parameter int MAX_RADIUS = DefMaxRadius,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int RHW   = $clog2(MAX_HEIGHT),
  localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int RADW  = $clog2(MAX_RADIUS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic [CW-1:0]   last_x,
  input  logic [RHW-1:0]  last_y,
  input  logic [RADW-1:0] r,
  input  logic [8:0]      thr,
  output logic            busy,
  output logic            done,
  output logic [AW-1:0]   src_raddr,
  input  logic [7:0]      src_rdata,
  output logic            res_we,
  output logic [AW-1:0]   res_waddr,
  output logic [7:0]      res_wdata
);

  localparam int PW     = (CW > RHW) ? CW : RHW;
  localparam int TW     = $clog2(2 * MAX_RADIUS + 1);
  localparam int WTW    = $clog2(MAX_RADIUS + 2);
  localparam int DSW    = $clog2((MAX_RADIUS + 1) * (MAX_RADIUS + 1) + 1);
  localparam int ACCW   = DSW + 9;
  localparam int QW     = $clog2(MAX_WIDTH + MAX_HEIGHT + 2 * MAX_RADIUS + 2) + 1;

  eng_state_t      state;
  logic            pass;
  logic [PW-1:0]   inner;
  logic [PW-1:0]   outer;
  logic [TW-1:0]   tap;
  logic            tap_v;
  logic [WTW-1:0]  wt_d;
  logic [ACCW-1:0] acc;
  logic [DSW-1:0]  dsum;
  logic [3:0]      step;
  logic [8:0]      quot;

  logic [PW-1:0]   inner_last;
  logic [PW-1:0]   outer_last;
  logic signed [QW-1:0] qpos;
  logic [PW-1:0]   qc;
  logic [TW:0]     wt_full;
  logic [WTW-1:0]  wt;
  logic [7:0]      pix;
  logic [7:0]      rp_rdata;
  logic [AW-1:0]   rd_addr;
  logic            rp_we;
  logic [8+WTW-1:0] prod;
  logic            hit;
  logic [ACCW-1:0] dshift;
  logic            ge;
  logic            pix_end;
  logic            outer_end;

  function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] y, input logic [PW-1:0] x);
    addr_of = AW'(AW'(y) * AW'(MAX_WIDTH) + AW'(x));
  endfunction

  assign inner_last = pass ? PW'(last_y) : PW'(last_x);
  assign outer_last = pass ? PW'(last_x) : PW'(last_y);

  // Tap position, clamped to the edge of the current row or column.
  always_comb begin
    qpos = $signed(QW'(inner)) - $signed(QW'(r)) + $signed(QW'(tap));
    if (qpos[QW-1]) begin
      qc = '0;
    end else if (qpos > $signed(QW'(inner_last))) begin
      qc = inner_last;
    end else begin
      qc = PW'(qpos);
    end
  end

  always_comb begin
    if ((TW + 1)'(tap) <= (TW + 1)'(r)) begin
      wt_full = (TW + 1)'(tap) + (TW + 1)'(1);
    end else begin
      wt_full = (TW + 1)'({r, 1'b1}) - (TW + 1)'(tap);
    end
    wt = WTW'(wt_full);
  end

  assign rd_addr   = pass ? addr_of(qc, outer) : addr_of(outer, qc);
  assign src_raddr = rd_addr;
  assign pix       = pass ? rp_rdata : src_rdata;
  assign prod      = {{WTW{1'b0}}, pix} * {8'd0, wt_d};
  assign hit       = $signed({1'b0, pix}) > $signed(thr);
  assign dshift    = ACCW'(dsum) << step;
  assign ge        = acc >= dshift;

  assign res_wdata = (dsum == '0) ? 8'd0 : (quot[8] ? 8'hFF : quot[7:0]);
  assign res_waddr = pass ? addr_of(inner, outer) : addr_of(outer, inner);
  assign rp_we     = (state == S_WRITE) && !pass;
  assign res_we    = (state == S_WRITE) && pass;
  assign busy      = (state != S_IDLE);
  assign pix_end   = (inner == inner_last);
  assign outer_end = (outer == outer_last);

  tbsb_ram #(
    .WIDTH(8),
    .DEPTH(MAX_WIDTH * MAX_HEIGHT)
  ) u_row_pass (
    .clk  (clk),
    .we   (rp_we),
    .waddr(res_waddr),
    .wdata(res_wdata),
    .raddr(rd_addr),
    .rdata(rp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap_v <= 1'b0;
      done  <= 1'b0;
    end else begin
      done  <= 1'b0;
      tap_v <= (state == S_TAP);
      unique case (state)
        S_IDLE: begin
          if (go) begin
            state <= S_TAP;
          end
        end
        S_TAP: begin
          if (tap == TW'({r, 1'b0})) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == 4'd0) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (pix_end && outer_end && pass) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_TAP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tap_v) begin
      acc <= acc + ACCW'(prod);
      if (hit) begin
        dsum <= dsum + DSW'(wt_d);
      end
    end
    case (state)
      S_IDLE: begin
        pass  <= 1'b0;
        inner <= '0;
        outer <= '0;
        tap   <= '0;
        acc   <= '0;
        dsum  <= '0;
      end
      S_TAP: begin
        tap  <= tap + TW'(1);
        wt_d <= wt;
      end
      S_LAST: begin
        step <= 4'd8;
        quot <= '0;
      end
      S_DIV: begin
        if (ge) begin
          acc        <= acc - dshift;
          quot[step] <= 1'b1;
        end
        step <= step - 4'd1;
      end
      S_WRITE: begin
        tap  <= '0;
        acc  <= '0;
        dsum <= '0;
        if (pix_end) begin
          inner <= '0;
          if (outer_end) begin
            outer <= '0;
            pass  <= 1'b1;
          end else begin
            outer <= outer + PW'(1);
          end
        end else begin
          inner <= inner + PW'(1);
        end
      end
      default: ;
    endcase
  end

  a_last_to_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_LAST) |=> (state == S_DIV))
    else $error("tap phase did not hand over to the divider");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE) && $past(state == S_WRITE))
    else $error("run completion outside the final write");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (step <= 4'd8))
    else $error("divider step out of range");

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the threshold weighted separable blur.
module tb_top;
  import tbsb_pkg::*;

  // Expected contents of one result strobe.
  typedef struct packed {
    logic [7:0] read_pixel;
    logic       run_done;
    logic       status;
  } blur_outcome_t;

  localparam int FrameDim = 256;
  localparam int StoreDepth = FrameDim * FrameDim;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          func;
  logic [7:0]          col;
  logic [7:0]          row;
  logic [7:0]          pixel_value;
  logic                done;
  logic [7:0]          read_pixel;
  logic                run_done;
  logic                status;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  threshold_weighted_separable_blur u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .col         (col),
    .row         (row),
    .pixel_value (pixel_value),
    .done        (done),
    .read_pixel  (read_pixel),
    .run_done    (run_done),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Shadow copies of the three frame stores. The written flags keep the
  // stimulus away from entries whose contents the block leaves undefined.
  logic [7:0] src_img   [StoreDepth];
  logic [7:0] hpass_img [StoreDepth];
  logic [7:0] blur_img  [StoreDepth];
  bit         src_ok    [StoreDepth];
  bit         blur_ok   [StoreDepth];

  // Shadow copies of the configuration registers, as written.
  logic [8:0] frame_w_reg;
  logic [8:0] frame_h_reg;
  logic [4:0] radius_reg;
  logic [8:0] thresh_reg;

  blur_outcome_t pending_outcomes[$];
  int            fails;
  int            idle_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Width and height clamp into 1..256; zero behaves as one.
  function automatic int eff_size(logic [8:0] v);
    if (v == 9'd0) return 1;
    if (v > 9'd256) return 256;
    return int'(v);
  endfunction

  // One output pixel of either pass. The numerator takes every tap, while the
  // denominator only takes the weights of taps strictly above the threshold.
  function automatic logic [7:0] blur_tap_sum(bit vert, int x, int y, int w, int h,
                                              int r, int t);
    int unsigned acc;
    int unsigned wsum;
    int          q;
    int          p;
    int          f;
    acc = 0;
    wsum = 0;
    for (int k = -r; k <= r; k++) begin
      if (vert) begin
        q = y + k;
        if (q < 0) q = 0;
        if (q > h - 1) q = h - 1;
        p = hpass_img[q * FrameDim + x];
      end else begin
        q = x + k;
        if (q < 0) q = 0;
        if (q > w - 1) q = w - 1;
        p = src_img[y * FrameDim + q];
      end
      f = r + 1 - (k < 0 ? -k : k);
      acc += p * f;
      if (p > t) wsum += f;
    end
    if (wsum == 0) return 8'd0;
    acc = acc / wsum;
    return (acc > 255) ? 8'd255 : acc[7:0];
  endfunction

  // Full two-pass filter over the configured frame, horizontal pass first.
  function automatic void blur_frame();
    int w;
    int h;
    int r;
    int t;
    w = eff_size(frame_w_reg);
    h = eff_size(frame_h_reg);
    r = int'(radius_reg);
    t = int'($signed(thresh_reg));
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        hpass_img[y * FrameDim + x] = blur_tap_sum(1'b0, x, y, w, h, r, t);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        blur_img[y * FrameDim + x] = blur_tap_sum(1'b1, x, y, w, h, r, t);
        blur_ok[y * FrameDim + x] = 1'b1;
      end
  endfunction

  // Updates the shadow state for one accepted command and queues its outcome.
  function automatic void predict_command(func_t f, logic [7:0] c, logic [7:0] r,
                                          logic [7:0] v);
    blur_outcome_t o;
    bit            in_frame;
    int            addr;
    o = '0;
    addr = int'(r) * FrameDim + int'(c);
    in_frame = (int'(c) < eff_size(frame_w_reg)) && (int'(r) < eff_size(frame_h_reg));
    case (f)
      FUNC_WRITE: begin
        if (in_frame) begin
          src_img[addr] = v;
          src_ok[addr] = 1'b1;
        end else begin
          o.status = 1'b1;
        end
      end
      FUNC_RUN: begin
        blur_frame();
        o.run_done = 1'b1;
      end
      FUNC_READ: begin
        if (in_frame) o.read_pixel = blur_img[addr];
        else o.status = 1'b1;
      end
      default: ;
    endcase
    pending_outcomes.push_back(o);
  endfunction

  // Sends one command and waits for its transfer. Start stays high afterwards
  // unless a random gap is taken, so back-to-back commands stay back to back.
  task automatic issue_cmd(func_t f, logic [7:0] c, logic [7:0] r, logic [7:0] v);
    start <= 1'b1;
    func <= f;
    col <= c;
    row <= r;
    pixel_value <= v;
    do @(posedge clk); while (busy);
    predict_command(f, c, r, v);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drops start and waits until every outstanding result has come back, plus
  // a margin for the result strobe.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  frame_w_reg = val;
      CFG_FRAME_HEIGHT: frame_h_reg = val;
      CFG_RADIUS:       radius_reg = val[4:0];
      default:          thresh_reg = val;
    endcase
  endtask

  task automatic set_config(logic [8:0] w, logic [8:0] h, logic [4:0] r, logic [8:0] t);
    drain();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_RADIUS, {4'd0, r});
    write_reg(CFG_THRESHOLD, t);
  endtask

  // Intensities lean toward the extremes so the threshold and saturation
  // corners come up often.
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A command the block answers without changing a defined store entry:
  // out-of-frame write or read, the unused code, or a read of a produced pixel.
  task automatic issue_noise();
    int         w;
    int         h;
    logic [7:0] c;
    logic [7:0] r;
    w = eff_size(frame_w_reg);
    h = eff_size(frame_h_reg);
    c = 8'($urandom_range(0, 255));
    r = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0, 1: begin
        if (w < 256) c = 8'($urandom_range(w, 255));
        else if (h < 256) r = 8'($urandom_range(h, 255));
        issue_cmd($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ, c, r, pick_pixel());
      end
      2: issue_cmd(FUNC_NONE, c, r, 8'($urandom_range(0, 255)));
      default: begin
        c = 8'($urandom_range(0, w - 1));
        r = 8'($urandom_range(0, h - 1));
        if (blur_ok[int'(r) * FrameDim + int'(c)]) issue_cmd(FUNC_READ, c, r, 8'd0);
        else issue_cmd(FUNC_NONE, c, r, 8'd0);
      end
    endcase
  endtask

  // Writes every pixel of the configured frame, sprinkled with noise.
  task automatic load_frame();
    for (int y = 0; y < eff_size(frame_h_reg); y++)
      for (int x = 0; x < eff_size(frame_w_reg); x++) begin
        if ($urandom_range(0, 99) < 15) issue_noise();
        issue_cmd(FUNC_WRITE, 8'(x), 8'(y), pick_pixel());
      end
  endtask

  task automatic read_back(int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 15) issue_noise();
      issue_cmd(FUNC_READ, 8'($urandom_range(0, eff_size(frame_w_reg) - 1)),
                8'($urandom_range(0, eff_size(frame_h_reg) - 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Small frame, every command code, out-of-frame coordinates, then a case
  // where the quotient has to saturate.
  task automatic test_directed();
    set_config(9'd3, 9'd2, 5'd1, 9'h1FF);
    issue_cmd(FUNC_WRITE, 8'd0, 8'd0, 8'd0);
    issue_cmd(FUNC_WRITE, 8'd1, 8'd0, 8'd255);
    issue_cmd(FUNC_WRITE, 8'd2, 8'd0, 8'd17);
    issue_cmd(FUNC_WRITE, 8'd0, 8'd1, 8'd255);
    issue_cmd(FUNC_WRITE, 8'd1, 8'd1, 8'd0);
    issue_cmd(FUNC_WRITE, 8'd2, 8'd1, 8'd128);
    issue_cmd(FUNC_WRITE, 8'd255, 8'd255, 8'd255);
    issue_cmd(FUNC_NONE, 8'd255, 8'd255, 8'd255);
    issue_cmd(FUNC_RUN, 8'd0, 8'd0, 8'd0);
    for (int i = 0; i < 6; i++) issue_cmd(FUNC_READ, 8'(i % 3), 8'(i / 3), 8'd0);
    issue_cmd(FUNC_READ, 8'd3, 8'd0, 8'd0);
    // High taps sit above the threshold alone, so the divisor is far too
    // small for the full weighted sum and the quotient clips at 255.
    set_config(9'd3, 9'd1, 5'd1, 9'd200);
    issue_cmd(FUNC_WRITE, 8'd0, 8'd0, 8'd150);
    issue_cmd(FUNC_WRITE, 8'd1, 8'd0, 8'd150);
    issue_cmd(FUNC_WRITE, 8'd2, 8'd0, 8'd250);
    issue_cmd(FUNC_RUN, 8'd0, 8'd0, 8'd0);
    for (int i = 0; i < 3; i++) issue_cmd(FUNC_READ, 8'(i), 8'd0, 8'd0);
  endtask

  // Register extremes: zero sizes, oversize width, full-length rows and
  // columns, largest radius, and the threshold at both ends.
  task automatic test_frame_extremes();
    set_config(9'd0, 9'd0, 5'd31, 9'h1FF);
    issue_cmd(FUNC_WRITE, 8'd0, 8'd0, 8'd201);
    issue_cmd(FUNC_WRITE, 8'd1, 8'd0, 8'd5);
    issue_cmd(FUNC_RUN, 8'd0, 8'd0, 8'd0);
    issue_cmd(FUNC_READ, 8'd0, 8'd0, 8'd0);
    issue_cmd(FUNC_READ, 8'd0, 8'd1, 8'd0);
    set_config(9'd511, 9'd1, 5'd31, 9'h1FF);
    load_frame();
    issue_cmd(FUNC_RUN, 8'd0, 8'd0, 8'd0);
    read_back(24);
    set_config(9'd1, 9'd256, 5'd0, 9'd255);
    load_frame();
    issue_cmd(FUNC_RUN, 8'd0, 8'd0, 8'd0);
    read_back(12);
    set_config(9'd1, 9'd256, 5'd31, 9'd254);
    issue_cmd(FUNC_RUN, 8'd0, 8'd0, 8'd0);
    read_back(24);
  endtask

  // Each pass of the loop picks a fresh configuration, fills the frame, runs
  // the filter and reads the result back, with noise mixed in throughout.
  task automatic test_random(int pct, int passes);
    logic [8:0] w;
    logic [8:0] h;
    logic [8:0] t;
    idle_pct = pct;
    repeat (passes) begin
      w = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(7, 16)) : 9'($urandom_range(0, 6));
      h = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(7, 16)) : 9'($urandom_range(0, 6));
      case ($urandom_range(0, 3))
        0: t = 9'h1FF;
        1: t = 9'd255;
        default: t = 9'($urandom_range(0, 255));
      endcase
      set_config(w, h, 5'($urandom_range(0, 31)), t);
      load_frame();
      repeat ($urandom_range(0, 3)) issue_noise();
      issue_cmd(FUNC_RUN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
      read_back($urandom_range(4, 2 * eff_size(frame_w_reg) * eff_size(frame_h_reg)));
    end
  endtask

  // Every strobe is matched against the oldest outstanding expectation.
  always @(posedge clk) begin
    blur_outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result strobe with nothing expected: read_pixel %0d run_done %0b status %0b",
                 $time, read_pixel, run_done, status);
        fails++;
      end else begin
        want = pending_outcomes.pop_front();
        if (read_pixel !== want.read_pixel) begin
          $display("%0t: read_pixel expected %0d actual %0d", $time, want.read_pixel, read_pixel);
          fails++;
        end
        if (run_done !== want.run_done) begin
          $display("%0t: run_done expected %0b actual %0b", $time, want.run_done, run_done);
          fails++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0b actual %0b", $time, want.status, status);
          fails++;
        end
      end
    end
  end

  initial begin
    #40000000;
    $display("threshold_weighted_separable_blur regression: fail");
    $finish;
  end

  initial begin
    fails = 0;
    idle_pct = 28;
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_NONE;
    col = '0;
    row = '0;
    pixel_value = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    frame_w_reg = RstFrameWidth;
    frame_h_reg = RstFrameHeight;
    radius_reg = RstRadius;
    thresh_reg = RstThreshold;
    for (int i = 0; i < StoreDepth; i++) begin
      src_ok[i] = 1'b0;
      blur_ok[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_frame_extremes();
    test_random(28, 6);
    test_random(81, 6);
    test_random(0, 6);
    drain();
    if (fails == 0) begin
      $display("threshold_weighted_separable_blur regression: pass");
    end else begin
      $display("threshold_weighted_separable_blur regression: fail");
    end
    $finish;
  end

endmodule
